FILE: rtl/cdad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_pkg: shared types and constants for the calendar date adder
// Microcode opcodes, jump conditions, step addresses and calendar helpers.
// ----------------------------------------------------------------------------
package cdad_pkg;

  localparam int MAX_YEAR = 9999;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OFF_W   = 17;
  localparam int STAT_W  = 2;

  // Internal widths: the year walk can run past the input range by the
  // offset span, and the day count covers one year plus the offset.
  localparam int YW_W  = 15;
  localparam int NUM_W = 18;
  localparam int DOY_W = 9;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam int PC_W = 4;
  localparam int K_W  = 3;

  // Largest shift of 400 that still fits below the input year range.
  localparam logic [K_W-1:0] MOD_K_TOP = K_W'(5);
  localparam logic [YW_W-1:0] YEAR_CYCLE = YW_W'(400);

  localparam logic [PC_W-1:0] PC_IDLE  = PC_W'(0);
  localparam logic [PC_W-1:0] PC_MOD   = PC_W'(1);
  localparam logic [PC_W-1:0] PC_CHECK = PC_W'(2);
  localparam logic [PC_W-1:0] PC_YDN   = PC_W'(3);
  localparam logic [PC_W-1:0] PC_UNDER = PC_W'(4);
  localparam logic [PC_W-1:0] PC_YUP   = PC_W'(5);
  localparam logic [PC_W-1:0] PC_RANGE = PC_W'(6);
  localparam logic [PC_W-1:0] PC_MON   = PC_W'(7);
  localparam logic [PC_W-1:0] PC_OUT   = PC_W'(8);
  localparam logic [PC_W-1:0] PC_LAST  = PC_OUT;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_BAD_DATE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_MOD,
    OP_CHECK,
    OP_YDN,
    OP_UNDER,
    OP_YUP,
    OP_RANGE,
    OP_MON,
    OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_IN,
    C_K_NZ,
    C_BAD,
    C_NEG_NZ,
    C_NEG,
    C_GE_YLEN,
    C_OVER,
    C_GE_MLEN,
    C_BUSY
  } cond_e;

  typedef struct packed {
    op_e             op;
    cond_e           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic no_in;
    logic k_nz;
    logic bad;
    logic neg_nz;
    logic neg;
    logic ge_ylen;
    logic over;
    logic ge_mlen;
    logic busy;
  } flags_t;

  typedef struct packed {
    status_e              status;
    logic [DAY_W-1:0]     day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
  } result_t;

  // Leap test from the year taken modulo 400.
  function automatic logic is_leap(input logic [YW_W-1:0] r);
    is_leap = (r[1:0] == 2'b00) && (r != YW_W'(100)) && (r != YW_W'(200)) &&
              (r != YW_W'(300));
  endfunction

  function automatic logic [DOY_W-1:0] year_len(input logic leap);
    year_len = leap ? DOY_W'(366) : DOY_W'(365);
  endfunction

  // Month length; zero for codes that are not a month.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = DAY_W'(31);
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = DAY_W'(30);
      4'd2:    month_len = leap ? DAY_W'(29) : DAY_W'(28);
      default: month_len = '0;
    endcase
  endfunction

  // Days in the months before m in a common year.
  function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
    unique case (m)
      4'd2:    days_before_month = DOY_W'(31);
      4'd3:    days_before_month = DOY_W'(59);
      4'd4:    days_before_month = DOY_W'(90);
      4'd5:    days_before_month = DOY_W'(120);
      4'd6:    days_before_month = DOY_W'(151);
      4'd7:    days_before_month = DOY_W'(181);
      4'd8:    days_before_month = DOY_W'(212);
      4'd9:    days_before_month = DOY_W'(243);
      4'd10:   days_before_month = DOY_W'(273);
      4'd11:   days_before_month = DOY_W'(304);
      4'd12:   days_before_month = DOY_W'(334);
      default: days_before_month = '0;
    endcase
  endfunction

endpackage

FILE: rtl/cdad_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_seq: microcode sequencer
// Step counter, control store and conditional jump selection.
// ----------------------------------------------------------------------------
module cdad_seq import cdad_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  output ctrl_t  ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;
  logic            take;

  // Control store: each step runs its operation, then jumps to the target
  // while its condition holds and otherwise falls through.
  always_comb begin
    unique case (pc_q)
      PC_IDLE:  ctrl = '{op: OP_LOAD,  cond: C_NO_IN,   target: PC_IDLE};
      PC_MOD:   ctrl = '{op: OP_MOD,   cond: C_K_NZ,    target: PC_MOD};
      PC_CHECK: ctrl = '{op: OP_CHECK, cond: C_BAD,     target: PC_OUT};
      PC_YDN:   ctrl = '{op: OP_YDN,   cond: C_NEG_NZ,  target: PC_YDN};
      PC_UNDER: ctrl = '{op: OP_UNDER, cond: C_NEG,     target: PC_OUT};
      PC_YUP:   ctrl = '{op: OP_YUP,   cond: C_GE_YLEN, target: PC_YUP};
      PC_RANGE: ctrl = '{op: OP_RANGE, cond: C_OVER,    target: PC_OUT};
      PC_MON:   ctrl = '{op: OP_MON,   cond: C_GE_MLEN, target: PC_MON};
      PC_OUT:   ctrl = '{op: OP_OUT,   cond: C_BUSY,    target: PC_OUT};
      default:  ctrl = '{op: OP_NOP,   cond: C_ALWAYS,  target: PC_IDLE};
    endcase
  end

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:  take = 1'b1;
      C_NO_IN:   take = flags_i.no_in;
      C_K_NZ:    take = flags_i.k_nz;
      C_BAD:     take = flags_i.bad;
      C_NEG_NZ:  take = flags_i.neg_nz;
      C_NEG:     take = flags_i.neg;
      C_GE_YLEN: take = flags_i.ge_ylen;
      C_OVER:    take = flags_i.over;
      C_GE_MLEN: take = flags_i.ge_mlen;
      C_BUSY:    take = flags_i.busy;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_d = ctrl.target;
    end else if (pc_q == PC_LAST) begin
      pc_d = PC_IDLE;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

FILE: rtl/cdad_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_dpath: date walking datapath
// Year, year-mod-400, month and day-count registers driven by microcode.
// ----------------------------------------------------------------------------
module cdad_dpath import cdad_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctrl_t                 ctrl_i,
  input  logic                  in_valid_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic                  out_free_i,
  output logic                  in_ready_o,
  output flags_t                flags_o,
  output logic                  res_load_o,
  output result_t               res_o
);

  logic [YW_W-1:0]          y_q, y_d;
  logic [YW_W-1:0]          r_q, r_d;
  logic [MONTH_W-1:0]       m_q, m_d;
  logic [DAY_W-1:0]         d_q, d_d;
  logic signed [OFF_W-1:0]  off_q, off_d;
  logic signed [NUM_W-1:0]  n_q, n_d;
  logic [K_W-1:0]           k_q, k_d;
  status_e                  st_q, st_d;

  logic [YW_W-1:0]          r_inc, r_dec, mod_sub;
  logic                     leap_cur, leap_dec, mod_ge;
  logic signed [NUM_W-1:0]  ylen_cur_s, ylen_dec_s, mlen_s, doy_s;
  logic [DAY_W-1:0]         mlen;
  logic [DOY_W-1:0]         doy;
  logic                     neg, bad, ge_ylen, ge_mlen, over;

  assign leap_cur = is_leap(r_q);
  assign r_inc    = (r_q == YEAR_CYCLE - YW_W'(1)) ? '0 : r_q + YW_W'(1);
  assign r_dec    = (r_q == '0) ? YEAR_CYCLE - YW_W'(1) : r_q - YW_W'(1);
  assign leap_dec = is_leap(r_dec);

  assign ylen_cur_s = signed'(NUM_W'(year_len(leap_cur)));
  assign ylen_dec_s = signed'(NUM_W'(year_len(leap_dec)));
  assign mlen       = month_len(m_q, leap_cur);
  assign mlen_s     = signed'(NUM_W'(mlen));

  // Conditional subtract of 400 shifted left, one shift per step.
  assign mod_sub = YEAR_CYCLE << k_q;
  assign mod_ge  = r_q >= mod_sub;

  // Day of the year of the start date, counted from zero.
  assign doy   = days_before_month(m_q) + DOY_W'(leap_cur && (m_q > MONTH_W'(2))) +
                 DOY_W'(d_q) - DOY_W'(1);
  assign doy_s = signed'(NUM_W'(doy));

  assign neg     = n_q < 0;
  assign bad     = (m_q == '0) || (m_q > MONTH_W'(12)) || (d_q == '0) || (d_q > mlen);
  assign ge_ylen = n_q >= ylen_cur_s;
  assign ge_mlen = (m_q < MONTH_W'(12)) && (n_q >= mlen_s);
  assign over    = {2'b00, y_q} > 17'(MAX_YEAR);

  assign in_ready_o = (ctrl_i.op == OP_LOAD);
  assign res_load_o = (ctrl_i.op == OP_OUT) && out_free_i;

  always_comb begin
    flags_o         = '0;
    flags_o.no_in   = !in_valid_i;
    flags_o.k_nz    = (k_q != '0);
    flags_o.bad     = bad;
    flags_o.neg_nz  = neg && (y_q != '0);
    flags_o.neg     = neg;
    flags_o.ge_ylen = ge_ylen;
    flags_o.over    = over;
    flags_o.ge_mlen = ge_mlen;
    flags_o.busy    = !out_free_i;
  end

  always_comb begin
    y_d   = y_q;
    r_d   = r_q;
    m_d   = m_q;
    d_d   = d_q;
    off_d = off_q;
    n_d   = n_q;
    k_d   = k_q;
    st_d  = st_q;
    unique case (ctrl_i.op)
      OP_LOAD: begin
        if (in_valid_i) begin
          y_d   = {1'b0, in_data_i[13:0]};
          r_d   = {1'b0, in_data_i[13:0]};
          m_d   = in_data_i[17:14];
          d_d   = in_data_i[22:18];
          off_d = signed'(in_data_i[39:23]);
          k_d   = MOD_K_TOP;
          st_d  = ST_OK;
        end
      end
      OP_MOD: begin
        if (mod_ge) begin
          r_d = r_q - mod_sub;
        end
        k_d = k_q - K_W'(1);
      end
      OP_CHECK: begin
        if (bad) begin
          st_d = ST_BAD_DATE;
        end else begin
          n_d = NUM_W'(off_q) + doy_s;
        end
      end
      OP_YDN: begin
        if (neg && (y_q != '0)) begin
          y_d = y_q - YW_W'(1);
          r_d = r_dec;
          n_d = n_q + ylen_dec_s;
        end
      end
      OP_UNDER: begin
        if (neg) begin
          st_d = ST_RANGE;
        end
      end
      OP_YUP: begin
        if (ge_ylen) begin
          y_d = y_q + YW_W'(1);
          r_d = r_inc;
          n_d = n_q - ylen_cur_s;
        end
      end
      OP_RANGE: begin
        if (over) begin
          st_d = ST_RANGE;
        end
        m_d = MONTH_W'(1);
      end
      OP_MON: begin
        if (ge_mlen) begin
          m_d = m_q + MONTH_W'(1);
          n_d = n_q - mlen_s;
        end
      end
      OP_OUT, OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      st_q <= ST_OK;
    end else begin
      k_q  <= k_d;
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q   <= y_d;
    r_q   <= r_d;
    m_q   <= m_d;
    d_q   <= d_d;
    off_q <= off_d;
    n_q   <= n_d;
  end

  // Error results carry zero date fields.
  always_comb begin
    res_o        = '0;
    res_o.status = st_q;
    if (st_q == ST_OK) begin
      res_o.year  = y_q[YEAR_W-1:0];
      res_o.month = m_q;
      res_o.day   = n_q[DAY_W-1:0] + DAY_W'(1);
    end
  end

endmodule

FILE: rtl/calendar_date_add_days_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_add_days_top: Gregorian date plus signed day offset
// A microcoded sequencer walks the calendar year by year, then month by month.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         year_in, month_in, day_in, day_offset
//  m_axis    out        year_out, month_out, day_out, status
//
// One request is in flight at a time. The year walk step of the sequencer
// steps through every year crossed by the offset, then the month walk step
// steps through every month passed. A request with an invalid start date
// skips both walks and goes straight to the output step.
// Reset is asynchronous; the block is ready for a request right after it.
// A finished result waits in the output register while the next request is
// taken in, and the sequencer only stalls if that register is still full.
// ----------------------------------------------------------------------------
module calendar_date_add_days_top import cdad_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [13:0] year_in, [17:14] month_in, [22:18] day_in, [39:23] day_offset
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [13:0] year_out, [17:14] month_out, [22:18] day_out, [24:23] status
  output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  ctrl_t   ctrl;
  flags_t  flags;
  result_t res;
  logic    res_load, out_free;
  logic    out_vld_q, out_vld_d;
  result_t out_q;

  cdad_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  cdad_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .flags_o    (flags),
    .res_load_o (res_load),
    .res_o      (res)
  );

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    out_vld_d = out_vld_q && !m_axis_tready;
    if (res_load) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OUT_DATA_W'(out_q);

endmodule

FILE: rtl/cdad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdad_checker: port-level checks for the date adder
// Watches both stream channels of the top level; bound to it below.
// ----------------------------------------------------------------------------
module cdad_checker import cdad_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [IN_DATA_W-1:0]   s_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  logic [STAT_W-1:0] st;
  assign st = m_axis_tdata[24:23];

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // One request at a time: an accepted request closes the input side.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in flight");

  // Error results carry zero date fields and a known status code.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st != STAT_W'(ST_OK)) |->
      (m_axis_tdata[22:0] == '0) &&
      ((st == STAT_W'(ST_BAD_DATE)) || (st == STAT_W'(ST_RANGE))))
    else $error("bad error result");

  // Good results have a month from 1 to 12, a nonzero day and a year within the year limit.
  a_ok_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (st == STAT_W'(ST_OK)) |->
      (m_axis_tdata[17:14] != '0) && (m_axis_tdata[17:14] <= 4'd12) &&
      (m_axis_tdata[22:18] != '0) &&
      ({3'b000, m_axis_tdata[13:0]} <= 17'(MAX_YEAR)))
    else $error("result date out of range");

endmodule

bind calendar_date_add_days_top cdad_checker u_cdad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
